// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants
// Request word layout, miss value and the word passed from front to back.
// ----------------------------------------------------------------------------
package lkvc_pkg;
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;
endpackage

// ----- sv/lkvc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel
// Valid/ready channel carrying one get or put request.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

// ----- sv/lkvc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_rsp_if: result channel
// Valid/ready channel carrying one get result.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;
  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

// ----- sv/lkvc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_queue: request queue
// Two-entry FIFO between the front end and the cache engine.
// ----------------------------------------------------------------------------
module lkvc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           flush,
  input  logic           wr_en,
  input  lkvc_pkg::req_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output lkvc_pkg::req_t rd_data
);
  lkvc_pkg::req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

// ----- sv/lkvc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_engine: cache engine
// Scans entries one per cycle for key match, oldest entry and free slot,
// then writes the result register and updates ages in a second sweep.
// ----------------------------------------------------------------------------
module lkvc_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         flush,
  input  logic [$clog2(CAPACITY+1)-1:0] cap_eff,
  input  logic                         req_valid,
  input  lkvc_pkg::req_t               req,
  output logic                         req_take,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         rsp_found,
  output logic [31:0]                  rsp_value
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY+1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_AGE  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Per-entry registers: each entry compared at its own fixed place is
  // avoided; keys/values are read at the scan index only.
  logic [31:0] key_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];
  logic [IW-1:0] age_r [CAPACITY];
  logic [CAPACITY-1:0] vld_r;
  logic [CW-1:0] used_r;

  logic [1:0]    st_r;
  lkvc_pkg::req_t cur_r;
  logic [IW-1:0] idx_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          old_ok_r;
  logic [IW-1:0] old_idx_r, old_age_r;
  logic          free_ok_r;
  logic [IW-1:0] free_idx_r;
  logic [IW-1:0] slot_r, thr_r;
  logic          newk_r;
  logic          rv_r, rf_r;
  logic [31:0]   rd_r;

  logic last;
  assign last      = (idx_r == IW'(CAPACITY-1));
  assign req_take  = (st_r == ST_IDLE) && req_valid && !rv_r;
  assign rsp_valid = rv_r;
  assign rsp_found = rf_r;
  assign rsp_value = rd_r;

  // Key store is read one entry ahead so the key for idx_r sits in a register.
  logic [31:0]   key_rd_r, hit_val_r;
  logic [IW-1:0] idx_inc;
  assign idx_inc = idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      st_r   <= ST_IDLE;
      vld_r  <= '0;
      used_r <= '0;
      rv_r   <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) age_r[i] <= '0;
    end else begin
      if (rv_r && rsp_ready) rv_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (req_take) begin
            cur_r     <= req;
            idx_r     <= '0;
            key_rd_r  <= key_mem[0];
            hit_r     <= 1'b0;
            old_ok_r  <= 1'b0;
            free_ok_r <= 1'b0;
            st_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (vld_r[idx_r]) begin
            if (!hit_r && key_rd_r == cur_r.key) begin
              hit_r     <= 1'b1;
              hit_idx_r <= idx_r;
              hit_val_r <= val_mem[idx_r];
            end
            if (!old_ok_r || age_r[idx_r] > old_age_r) begin
              old_ok_r  <= 1'b1;
              old_idx_r <= idx_r;
              old_age_r <= age_r[idx_r];
            end
          end else if (!free_ok_r) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= idx_r;
          end
          key_rd_r <= key_mem[idx_inc];
          idx_r    <= idx_inc;
          if (last) st_r <= ST_DONE;
        end
        ST_DONE: begin
          // Decide the action; age sweep follows unless a get misses or a put finds no slot.
          idx_r <= '0;
          if (hit_r) begin
            newk_r <= 1'b0;
            slot_r <= hit_idx_r;
            thr_r  <= age_r[hit_idx_r];
            if (cur_r.req_type == lkvc_pkg::REQ_PUT)
              val_mem[hit_idx_r] <= cur_r.value;
            else begin
              rv_r <= 1'b1;
              rf_r <= 1'b1;
              rd_r <= hit_val_r;
            end
            st_r <= ST_AGE;
          end else if (cur_r.req_type == lkvc_pkg::REQ_GET) begin
            rv_r <= 1'b1;
            rf_r <= 1'b0;
            rd_r <= lkvc_pkg::MISS_VALUE;
            st_r <= ST_IDLE;
          end else begin
            newk_r <= 1'b1;
            if (used_r >= cap_eff && old_ok_r) begin
              slot_r <= old_idx_r;
              vld_r[old_idx_r] <= 1'b0;
              key_mem[old_idx_r] <= cur_r.key;
              val_mem[old_idx_r] <= cur_r.value;
              used_r <= used_r - 1'b1;
              st_r <= ST_AGE;
            end else if (free_ok_r) begin
              slot_r <= free_idx_r;
              key_mem[free_idx_r] <= cur_r.key;
              val_mem[free_idx_r] <= cur_r.value;
              st_r <= ST_AGE;
            end else begin
              st_r <= ST_IDLE;
            end
          end
        end
        ST_AGE: begin
          // One entry per cycle: age younger (touch) or all valid (insert).
          if (idx_r == slot_r) begin
            age_r[idx_r] <= '0;
          end else if (vld_r[idx_r] && (newk_r || age_r[idx_r] < thr_r)) begin
            age_r[idx_r] <= age_r[idx_r] + 1'b1;
          end
          idx_r <= idx_inc;
          if (last) begin
            if (newk_r) begin
              vld_r[slot_r] <= 1'b1;
              used_r <= used_r + 1'b1;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: LRU key-value cache
// Fully associative get/put store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// channel | dir | handshake      | word
// in_     | in  | valid / ready  | req_type, key, value
// out_    | out | valid / ready  | found, read_value (gets only)
// cfg_    | in  | wr_en          | capacity_in_use
//
// A request passes through the engine as key scan, decide and age sweep
// (a get miss skips the age sweep); each sweep goes one entry per cycle
// over the entry store. The front queue holds two words while the
// engine works. Reset is synchronous; writing capacity empties the store.
// A result waits in the output register until taken; the next word is
// started once that register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lkvc_req_if.sink    in_ch,
  lkvc_rsp_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  localparam int CW = $clog2(CAPACITY+1);

  logic [4:0] cap_r;
  logic [CW-1:0] cap_eff;
  logic q_full, q_valid, take;
  lkvc_pkg::req_t q_in, q_out;
  logic [31:0] rd_val;

  // Hold the capacity register; zero acts as one, clamp to CAPACITY.
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= lkvc_pkg::CAP_RESET;
    else if (cfg_wr_en) cap_r <= cfg_wr_data;
  end

  always_comb begin
    if (cap_r == 5'd0) cap_eff = CW'(1);
    else if (32'(cap_r) > CAPACITY) cap_eff = CW'(CAPACITY);
    else cap_eff = CW'(cap_r);
  end

  assign in_ch.ready = !q_full;
  assign q_in = '{req_type: in_ch.req_type, key: in_ch.key, value: in_ch.value};

  lkvc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .flush(cfg_wr_en),
    .wr_en(in_ch.valid && !q_full), .wr_data(q_in), .full(q_full),
    .rd_valid(q_valid), .rd_en(take), .rd_data(q_out)
  );

  lkvc_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk(clk), .rst_n(rst_n), .flush(cfg_wr_en), .cap_eff(cap_eff),
    .req_valid(q_valid), .req(q_out), .req_take(take),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready),
    .rsp_found(out_ch.found), .rsp_value(rd_val)
  );

  assign out_ch.read_value = rd_val;
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: LRU key-value cache testbench
// Drives get/put words with random gaps and result stalls, and runs through
// several capacity settings. A recency-ordered copy of the store predicts
// every get result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int SLOTS = 16;
  localparam int MAX_SHOWN = 10;

  // Keeps its own copy of the store and the queue of get results still owed.
  class cache_tracker;
    bit          slot_used [SLOTS];
    logic [31:0] slot_key  [SLOTS];
    logic [31:0] slot_val  [SLOTS];
    int unsigned slot_rank [SLOTS];
    int unsigned fill;
    logic [4:0]  cap_reg;
    logic [32:0] owed_replies [$];   // {found, read_value}
    int          bad_count;

    function new();
      cap_reg = lkvc_pkg::CAP_RESET;
      clear_store();
      bad_count = 0;
    endfunction

    function void clear_store();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 0;
        slot_rank[i] = 0;
      end
      fill = 0;
    endfunction

    function void set_capacity(logic [4:0] c);
      cap_reg = c;
      clear_store();
    endfunction

    function int unsigned cap_limit();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function int lookup(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    // Promote one entry to most recent; younger entries age by one.
    function void promote(int idx);
      int unsigned r;
      r = slot_rank[idx];
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && i != idx && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[idx] = 0;
    endfunction

    function void insert_key(logic [31:0] k, logic [31:0] v);
      int          slot;
      int unsigned oldest;
      slot = -1;
      oldest = 0;
      if (fill >= cap_limit()) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && (slot < 0 || slot_rank[i] > oldest)) begin
            slot = i;
            oldest = slot_rank[i];
          end
        if (slot >= 0) begin
          slot_used[slot] = 0;
          fill--;
        end
      end
      if (slot < 0)
        for (int i = 0; i < SLOTS; i++)
          if (!slot_used[i]) begin
            slot = i;
            break;
          end
      if (slot < 0) return;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i]) slot_rank[i]++;
      slot_used[slot] = 1;
      slot_key[slot] = k;
      slot_val[slot] = v;
      slot_rank[slot] = 0;
      fill++;
    endfunction

    function void note_request(logic t, logic [31:0] k, logic [31:0] v);
      int idx;
      idx = lookup(k);
      if (t == lkvc_pkg::REQ_GET) begin
        if (idx < 0) owed_replies.push_back({1'b0, lkvc_pkg::MISS_VALUE});
        else begin
          promote(idx);
          owed_replies.push_back({1'b1, slot_val[idx]});
        end
      end else if (idx >= 0) begin
        slot_val[idx] = v;
        promote(idx);
      end else insert_key(k, v);
    endfunction

    function void check_reply(logic f, logic [31:0] rv);
      logic [32:0] exp_word;
      if (owed_replies.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("unexpected result: found=%0b read_value=%h", f, rv);
        return;
      end
      exp_word = owed_replies.pop_front();
      if (f !== exp_word[32] || rv !== exp_word[31:0]) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("result mismatch: expected found=%0b read_value=%h, %s%0b read_value=%h",
                   exp_word[32], exp_word[31:0], "got found=", f, rv);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  lkvc_req_if req_ch();
  lkvc_rsp_if rsp_ch();

  lru_key_value_cache_top #(.CAPACITY(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cache_tracker tracker;
  bit           quiet_sides;     // no idling on either side while set
  bit           long_hold_req;   // ask the receiver for one long hold-off
  logic [31:0]  key_pool [20];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int draw_gap();
    return quiet_sides ? 0 : $urandom_range(0, 11);
  endfunction

  // Offer one word; return at the edge where it is taken. Lower valid only
  // when a gap precedes the word, so valid never drops and rises in one step.
  task automatic send_word(logic t, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= t;
    req_ch.key      <= k;
    req_ch.value    <= v;
    // Inputs only move at the rising edge, so the falling edge sees stable values.
    forever begin
      @(negedge clk);
      if (req_ch.ready) break;
    end
    @(posedge clk);
    tracker.note_request(t, k, v);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (tracker.owed_replies.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Write the capacity once the engine is idle: puts owe no result, so
  // wait after the last result for any put still in the engine to finish.
  task automatic write_capacity(logic [4:0] c);
    req_ch.valid <= 1'b0;
    drain_results();
    repeat (120) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_capacity(c);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, 19)];
  endfunction

  task automatic random_phase(int count);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      // Hold a quiet stretch now and then so back-to-back traffic shows up.
      if (n % 40 == 0) quiet_sides = ($urandom_range(0, 3) == 0);
      send_word($urandom_range(0, 1) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET,
                pick_key(), $urandom);
    end
    quiet_sides = 0;
  endtask

  // Receiver: stall a random count before each result; take one long
  // hold-off when asked, counted here, while the sender keeps offering.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = draw_gap();
      if (long_hold_req) begin
        long_hold_req = 0;
        stall = 800;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (rsp_ch.valid) break;
      end
      tracker.check_reply(rsp_ch.found, rsp_ch.read_value);
      @(posedge clk);
    end
  end

  initial begin
    int wait_cycles;
    tracker = new();
    quiet_sides   = 0;
    long_hold_req = 0;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= lkvc_pkg::REQ_GET;
    req_ch.key      <= '0;
    req_ch.value    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-store miss, extreme keys and values, hit, update.
    send_word(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h1234_5678);
    send_word(lkvc_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(lkvc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(lkvc_pkg::REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0);
    send_word(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0);
    send_word(lkvc_pkg::REQ_PUT, 32'h0000_0000, 32'h0000_0005);
    send_word(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0);
    send_word(lkvc_pkg::REQ_GET, 32'h0000_007B, 32'h0);

    // Directed: capacity two, evict the least recent key.
    write_capacity(5'd2);
    send_word(lkvc_pkg::REQ_PUT, 32'd1, 32'd11);
    send_word(lkvc_pkg::REQ_PUT, 32'd2, 32'd22);
    send_word(lkvc_pkg::REQ_GET, 32'd1, 32'd0);
    send_word(lkvc_pkg::REQ_PUT, 32'd3, 32'd33);
    send_word(lkvc_pkg::REQ_GET, 32'd2, 32'd0);
    send_word(lkvc_pkg::REQ_GET, 32'd1, 32'd0);
    send_word(lkvc_pkg::REQ_GET, 32'd3, 32'd0);

    // Directed: zero capacity holds a single entry.
    write_capacity(5'd0);
    send_word(lkvc_pkg::REQ_PUT, 32'd7, 32'd70);
    send_word(lkvc_pkg::REQ_PUT, 32'd8, 32'd80);
    send_word(lkvc_pkg::REQ_GET, 32'd7, 32'd0);
    send_word(lkvc_pkg::REQ_GET, 32'd8, 32'd0);

    // Random phases across capacity settings, oversized ones included.
    write_capacity(5'd31);
    random_phase(140);
    write_capacity(5'd16);
    long_hold_req = 1;       // fill the front queue and stall the input
    random_phase(140);
    write_capacity(5'd1);
    random_phase(130);
    write_capacity(5'd4);
    random_phase(140);
    write_capacity(5'd17);
    random_phase(130);
    write_capacity(5'd9);
    random_phase(140);
    write_capacity(5'd0);
    random_phase(100);
    write_capacity(5'd16);
    random_phase(160);
    req_ch.valid <= 1'b0;

    drain_results();
    repeat (200) @(posedge clk);
    if (tracker.bad_count == 0 && tracker.owed_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
